### rtl/core/utf8_code_point_decoder_unit_macros.svh
// Assertion helpers used by the checker file of the decoder.
// Every property is sampled at the rising clock edge and is switched off while reset is held.
`ifndef UTF8_CODE_POINT_DECODER_UNIT_MACROS_SVH
`define UTF8_CODE_POINT_DECODER_UNIT_MACROS_SVH

// General form: the property must hold at every clock edge outside reset.
`define U8D_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Shorthand for a condition that must never be seen.
`define U8D_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `U8D_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

### rtl/core/utf8d_pkg.sv
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 22;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned PAY_W  = 18;

    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'h1f;
    localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'h0f;
    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3f;
    localparam logic [CNT_W-1:0]  SPAN_MAX     = 8'hff;
    // Continuation payloads are kept only while the span is at most this long.
    localparam logic [CNT_W-1:0]  SPAN_KEEP    = 8'd3;

    // One request from the front part to the back part.
    typedef struct packed {
        logic              has_char; // a closed character is reported
        logic              is_end;   // the zero terminator follows
        logic [CP_W-1:0]   code;
        logic [CNT_W-1:0]  count;
    } t_entry;

endpackage

### rtl/core/utf8d_front.sv
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_wr,
    output t_entry            o_entry
);

    logic              r_pending, n_pending;
    logic [BYTE_W-1:0] r_lead,    n_lead;
    logic [PAY_W-1:0]  r_payload, n_payload;
    logic [CNT_W-1:0]  r_span,    n_span;

    logic              is_zero;
    logic              is_cont;
    logic [CP_W-1:0]   code;
    logic [BYTE_W-1:0] lead2;
    logic [BYTE_W-1:0] lead3;
    logic [BYTE_W-1:0] low6;

    assign is_zero = (i_data_byte == '0);
    assign is_cont = ((i_data_byte & CONT_MASK) == CONT_TAG);
    assign lead2   = r_lead & LEAD2_MASK;
    assign lead3   = r_lead & LEAD3_MASK;
    assign low6    = i_data_byte & PAYLOAD_MASK;

    // The lead mask follows the number of bytes actually seen.
    always_comb begin
        if (r_span <= CNT_W'(1)) begin
            code = CP_W'(r_lead);
        end else if (r_span == CNT_W'(2)) begin
            code = CP_W'({lead2[4:0], r_payload[5:0]});
        end else if (r_span == CNT_W'(3)) begin
            code = CP_W'({lead3[3:0], r_payload[11:0]});
        end else begin
            code = {lead3[3:0], r_payload};
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_lead    = r_lead;
        n_payload = r_payload;
        n_span    = r_span;
        if (i_accept) begin
            if (is_zero) begin
                n_pending = 1'b0;
                n_lead    = '0;
                n_payload = '0;
                n_span    = '0;
            end else if (r_pending && is_cont) begin
                if (r_span <= SPAN_KEEP) begin
                    n_payload = {r_payload[PAY_W-7:0], low6[5:0]};
                end
                if (r_span != SPAN_MAX) begin
                    n_span = r_span + CNT_W'(1);
                end
            end else begin
                n_pending = 1'b1;
                n_lead    = i_data_byte;
                n_payload = '0;
                n_span    = CNT_W'(1);
            end
        end
    end

    assign o_wr           = i_accept && (is_zero || (r_pending && !is_cont));
    assign o_entry.has_char = r_pending;
    assign o_entry.is_end   = is_zero;
    assign o_entry.code     = code;
    assign o_entry.count    = r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_lead    <= '0;
            r_payload <= '0;
            r_span    <= '0;
        end else begin
            r_pending <= n_pending;
            r_lead    <= n_lead;
            r_payload <= n_payload;
            r_span    <= n_span;
        end
    end

endmodule

### rtl/core/utf8d_queue.sv
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wr_data,
    input  logic   i_rd,
    output t_entry o_rd_data,
    output logic   o_full,
    output logic   o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### rtl/core/utf8d_back.sv
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_entry           i_entry,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [CP_W-1:0]  o_code_point,
    output logic [CNT_W-1:0] o_consumed_bytes,
    output logic             o_end_of_string,
    output logic             o_last_of_run
);

    logic             r_valid,    n_valid;
    logic             r_end_pend, n_end_pend;
    logic [CP_W-1:0]  r_cp,       n_cp;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic             r_eos,      n_eos;
    logic             r_last,     n_last;
    logic             load;

    // The output register takes a new result when it is free or being drained.
    assign load    = !r_valid || i_pop;
    assign o_q_pop = load && !r_end_pend && !i_q_empty;

    always_comb begin
        n_valid    = r_valid;
        n_end_pend = r_end_pend;
        n_cp       = r_cp;
        n_cnt      = r_cnt;
        n_eos      = r_eos;
        n_last     = r_last;
        if (load) begin
            if (r_end_pend) begin
                n_valid    = 1'b1;
                n_end_pend = 1'b0;
                n_cp       = '0;
                n_cnt      = '0;
                n_eos      = 1'b1;
                n_last     = 1'b1;
            end else if (!i_q_empty) begin
                n_valid = 1'b1;
                if (i_entry.has_char) begin
                    // A terminator behind the character is sent on the next turn.
                    n_cp       = i_entry.code;
                    n_cnt      = i_entry.count;
                    n_eos      = 1'b0;
                    n_last     = !i_entry.is_end;
                    n_end_pend = i_entry.is_end;
                end else begin
                    n_cp   = '0;
                    n_cnt  = '0;
                    n_eos  = 1'b1;
                    n_last = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_end_pend <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_end_pend <= n_end_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_cnt  <= n_cnt;
        r_eos  <= n_eos;
        r_last <= n_last;
    end

    assign o_empty          = !r_valid;
    assign o_code_point     = r_cp;
    assign o_consumed_bytes = r_cnt;
    assign o_end_of_string  = r_eos;
    assign o_last_of_run    = r_last;

endmodule

### rtl/core/utf8_code_point_decoder_unit.sv
// Lenient UTF-8 decoder: a zero-terminated byte stream goes in, code points come out.
// The input side is a queue write port: a byte request is taken at a rising edge with
// i_push high and o_full low. The result side is a queue read port: the oldest result
// sits on the o_ payload ports while o_empty is low, and it leaves at an edge with
// i_pop high. A byte that closes a character yields one result; a zero byte yields the
// pending character (if any) and then an end result; a continuation byte yields none.
// A request enters the queue at the edge that takes its closing byte, and the output
// register loads it when free. Throughput: one byte per cycle in while o_full is low,
// and one result per cycle out while i_pop is high; the output register emits one
// result a cycle, so a zero byte that closes a character holds that port for two
// results. QUEUE_DEPTH requests sit between the byte classifier and the output
// stage, and o_full rises only once they are all taken up by a stalled receiver.
// While i_pop stays low the result on the ports holds; bytes keep being taken until
// the queue fills. Reset (synchronous, active low) drops any open character, empties
// the queue and the output register, and decoding then starts as on a fresh string.
// QUEUE_DEPTH must be at least 2.
module utf8_code_point_decoder_unit
    import utf8d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [CP_W-1:0]  o_code_point,
    output logic [CNT_W-1:0] o_consumed_bytes,
    output logic             o_end_of_string,
    output logic             o_last_of_run
);

    logic   accept;
    logic   q_wr;
    t_entry q_wr_data;
    t_entry q_rd_data;
    logic   q_rd;
    logic   q_empty;

    // A byte is taken whenever the queue has room; bytes that close nothing still count.
    assign accept = i_push && !o_full;

    // Front: keeps the open character and turns each byte into at most one request.
    utf8d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_wr        (q_wr),
        .o_entry     (q_wr_data)
    );

    // Short queue of requests so the front and the output stage stall independently.
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_full    (o_full),
        .o_empty   (q_empty)
    );

    // Back: expands each request into one or two results through the output register.
    utf8d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (q_rd_data),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_rd),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_code_point     (o_code_point),
        .o_consumed_bytes (o_consumed_bytes),
        .o_end_of_string  (o_end_of_string),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

### rtl/core/utf8d_checker.sv
`include "utf8_code_point_decoder_unit_macros.svh"

module utf8d_checker
    import utf8d_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_pop,
    input logic              o_empty,
    input logic [CP_W-1:0]   o_code_point,
    input logic [CNT_W-1:0]  o_consumed_bytes,
    input logic              o_end_of_string,
    input logic              o_last_of_run
);

    // An end result carries no character and always closes its run.
    `U8D_ASSERT(a_end_shape, i_clk, i_rst_n, (!o_empty && o_end_of_string) |-> (o_code_point == '0 && o_consumed_bytes == '0 && o_last_of_run), "end result with nonzero fields")

    // Every character result spans at least one byte.
    `U8D_ASSERT_NEVER(a_char_count, i_clk, i_rst_n, !o_empty && !o_end_of_string && o_consumed_bytes == '0, "character result with zero byte count")

    // A character that is not last in its run is flushed by a zero and the end follows at once.
    `U8D_ASSERT(a_end_follows, i_clk, i_rst_n, (!o_empty && !o_last_of_run && i_pop) |=> (!o_empty && o_end_of_string), "end result does not follow a flushed character")

    // A result that is not taken stays on the ports unchanged.
    `U8D_ASSERT(a_hold, i_clk, i_rst_n, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_code_point) && $stable(o_consumed_bytes) && $stable(o_end_of_string) && $stable(o_last_of_run)), "stalled result changed")

endmodule

bind utf8_code_point_decoder_unit utf8d_checker u_checker (.*);

### tb/tb_utf8_code_point_decoder_unit.sv
`timescale 1ns / 100ps

module tb_utf8_code_point_decoder_unit;
    import utf8d_pkg::*;

    // Cycles without any accepted request before the run is declared hung. The longest
    // legal silence is the forced receiver stall below plus a sender gap.
    localparam int STALL_LIMIT = 2000;
    // Length of the forced receiver stall that fills the internal queue.
    localparam int LONG_HOLD   = 300;
    // Rough item budget for the whole run.
    localparam int ITEM_TARGET = 700;

    // One decoded result as it should appear on the output ports.
    typedef struct packed {
        logic [CP_W-1:0]  code;
        logic [CNT_W-1:0] count;
        logic             eos;
        logic             last;
    } t_decoded_char;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_push      = 1'b0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_pop       = 1'b0;
    logic              o_full;
    logic              o_empty;
    logic [CP_W-1:0]   o_code_point;
    logic [CNT_W-1:0]  o_consumed_bytes;
    logic              o_end_of_string;
    logic              o_last_of_run;

    // Decoder state mirrored on the testbench side.
    logic              dec_open;
    logic [BYTE_W-1:0] dec_lead;
    logic [PAY_W-1:0]  dec_payload;
    logic [CNT_W-1:0]  dec_span;

    // Results still owed by the block, oldest first.
    t_decoded_char pending_results[$];
    t_decoded_char head_result;

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  quiet_cycles  = 0;
    int  pop_hold      = 0;
    bit  idle_on       = 1'b1;
    bit  long_hold_req = 1'b0;

    utf8_code_point_decoder_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_data_byte      (i_data_byte),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_code_point     (o_code_point),
        .o_consumed_bytes (o_consumed_bytes),
        .o_end_of_string  (o_end_of_string),
        .o_last_of_run    (o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    // Code point of the character that is open right now. The lead mask depends only on
    // how many bytes the character actually spanned, never on the lead byte itself.
    function automatic logic [CP_W-1:0] closed_code();
        logic [CP_W-1:0] lead_ext;
        lead_ext = CP_W'(dec_lead);
        if (dec_span <= 1)
            return lead_ext;
        if (dec_span == 2)
            return ((lead_ext & CP_W'(LEAD2_MASK)) << 6) | CP_W'(dec_payload[5:0]);
        if (dec_span == 3)
            return ((lead_ext & CP_W'(LEAD3_MASK)) << 12) | CP_W'(dec_payload[11:0]);
        return ((lead_ext & CP_W'(LEAD3_MASK)) << 18) | CP_W'(dec_payload);
    endfunction

    function automatic void clear_decoder();
        dec_open    = 1'b0;
        dec_lead    = '0;
        dec_payload = '0;
        dec_span    = '0;
    endfunction

    // Advances the mirrored decoder by one accepted byte and queues what it must emit.
    function automatic void predict_decode(input logic [BYTE_W-1:0] b);
        if (b == '0) begin
            // The terminator flushes an open character first, then reports the end.
            if (dec_open)
                pending_results.push_back('{closed_code(), dec_span, 1'b0, 1'b0});
            pending_results.push_back('{'0, '0, 1'b1, 1'b1});
            clear_decoder();
        end else if (dec_open && (b & CONT_MASK) == CONT_TAG) begin
            // Only the first three continuation payloads are kept; the count saturates.
            if (dec_span <= SPAN_KEEP)
                dec_payload = {dec_payload[PAY_W-7:0], b[5:0]};
            if (dec_span != SPAN_MAX)
                dec_span = dec_span + 1'b1;
        end else begin
            // Any other byte closes the open character and becomes the next lead. A stray
            // continuation byte with nothing open also lands here.
            if (dec_open)
                pending_results.push_back('{closed_code(), dec_span, 1'b0, 1'b1});
            dec_open    = 1'b1;
            dec_lead    = b;
            dec_payload = '0;
            dec_span    = 8'd1;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte();
        return CONT_TAG | (BYTE_W'($urandom) & PAYLOAD_MASK);
    endfunction

    // Offers one byte request and returns at the edge where it is accepted. The push
    // line is left high so that back-to-back requests follow without a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            if (i_push)
                i_push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        predict_decode(b);
        bytes_sent++;
    endtask

    // Stops offering requests until every owed result has been taken by the receiver.
    task automatic pause_until_drained();
        i_push <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // Mostly well-formed characters with random payloads, plus stray continuation
    // bytes, truncated sequences, overlong spans and raw noise.
    task automatic send_random_char();
        int kind;
        int n_cont;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            send_byte(BYTE_W'($urandom_range(1, 127)));
        end else if (kind < 50) begin
            send_byte({3'b110, 5'($urandom)});
            send_byte(cont_byte());
        end else if (kind < 65) begin
            send_byte({4'b1110, 4'($urandom)});
            repeat (2) send_byte(cont_byte());
        end else if (kind < 78) begin
            send_byte({5'b11110, 3'($urandom)});
            repeat (3) send_byte(cont_byte());
        end else if (kind < 84) begin
            n_cont = $urandom_range(4, 9);
            send_byte(BYTE_W'($urandom_range(8'hc0, 8'hff)));
            repeat (n_cont) send_byte(cont_byte());
        end else if (kind < 90) begin
            send_byte({4'b1111, 4'($urandom)});
            send_byte(cont_byte());
        end else if (kind < 96) begin
            send_byte(cont_byte());
        end else begin
            send_byte(BYTE_W'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random_string(input int max_chars);
        repeat ($urandom_range(0, max_chars)) send_random_char();
        send_byte('0);
    endtask

    // Hand-picked strings: end with nothing open, a stray continuation as lead, the ASCII
    // extremes, well-formed two, three and four byte characters, an overlong span on an
    // all-ones lead, and a one-byte string.
    task automatic test_directed();
        logic [BYTE_W-1:0] seq[$];
        seq = {8'h00, 8'h80, 8'h41, 8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
               8'hf0, 8'h9f, 8'h98, 8'h80, 8'hff, 8'hbf, 8'h80, 8'hbf, 8'h80,
               8'hbf, 8'h00, 8'h01, 8'h00};
        foreach (seq[k])
            send_byte(seq[k]);
    endtask

    // A character long enough to drive the byte count into saturation.
    task automatic test_span_saturation();
        send_byte({3'b110, 5'($urandom)});
        repeat (300) send_byte(cont_byte());
        send_byte(BYTE_W'($urandom_range(1, 127)));
        send_byte('0);
    endtask

    // The receiver stops taking results for a long time while requests keep coming, so
    // the queue inside the block fills and the input side stalls.
    task automatic test_receiver_stall();
        long_hold_req = 1'b1;
        repeat (24) send_byte(BYTE_W'($urandom_range(1, 127)));
        send_byte('0);
    endtask

    // The sender goes quiet until the block has handed over everything it owes, then
    // resumes in the middle of the open string and goes on with fresh strings.
    task automatic test_sender_drain();
        repeat (3) send_random_string(8);
        send_random_char();
        pause_until_drained();
        repeat (3) send_random_string(8);
    endtask

    task automatic test_random_strings(input int upto);
        while (bytes_sent < upto)
            send_random_string(12);
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_full_rate_tail();
        idle_on = 1'b0;
        while (bytes_sent < ITEM_TARGET)
            send_random_string(10);
    endtask

    // Receiver: checks each accepted result against the oldest expectation and decides
    // whether to take a result at the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: code=%h count=%0d eos=%b last=%b",
                             o_code_point, o_consumed_bytes, o_end_of_string,
                             o_last_of_run);
                mismatches++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_code_point !== head_result.code
                        || o_consumed_bytes !== head_result.count
                        || o_end_of_string !== head_result.eos
                        || o_last_of_run !== head_result.last) begin
                    if (mismatches < 10)
                        $display("mismatch: want code=%h count=%0d eos=%b last=%b, ",
                                 head_result.code, head_result.count, head_result.eos,
                                 head_result.last,
                                 "got code=%h count=%0d eos=%b last=%b",
                                 o_code_point, o_consumed_bytes,
                                 o_end_of_string, o_last_of_run);
                    mismatches++;
                end
            end
        end
        if (long_hold_req) begin
            pop_hold      = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold--;
            i_pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            // This edge is the first idle cycle of a burst; pop_hold counts the rest of it.
            pop_hold = $urandom_range(0, 14);
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    // Watchdog: any accepted request on either side resets the count.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        clear_decoder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_span_saturation();
        test_receiver_stall();
        test_sender_drain();
        test_random_strings(ITEM_TARGET - 70);
        test_full_rate_tail();

        // Let every owed result come out, then keep the receiver running so that any result
        // that nobody asked for shows up as a mismatch.
        pause_until_drained();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_queue.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_code_point_decoder_unit.sv
rtl/core/utf8d_checker.sv
tb/tb_utf8_code_point_decoder_unit.sv
